>>> rtl/core/dsp_pkg.sv
// Shared types, constants and helper functions for the date string parser.
package dsp_pkg;

  // Character codes of interest
  localparam logic [7:0] CHAR_DOT  = 8'd46;
  localparam logic [7:0] CHAR_DASH = 8'd45;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  // Saturation and range limits
  localparam logic [13:0] YEAR_SAT    = 14'd10000;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [8:0]  DAY_SAT     = 9'd367;
  localparam logic [8:0]  ORD_DAYS    = 9'd365;
  localparam logic [8:0]  ORD_DAYS_LP = 9'd366;
  localparam int unsigned LEAP_CYCLE  = 400;
  localparam logic [3:0]  CNT_MAX     = 4'd15;
  localparam logic [3:0]  ISO_LEN     = 4'd10;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [6:0]  MONTH_LAST  = 7'd12;

  // ISO flag bit positions
  localparam int FLAG_YEAR  = 0;
  localparam int FLAG_MONTH = 1;
  localparam int FLAG_DAY   = 2;
  localparam int FLAG_DASH  = 3;

  // Cumulative day count at the start of each month, non-leap year
  localparam logic [8:0] MONTH_START [12] =
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
      9'd304, 9'd334};
  localparam logic [4:0] MONTH_LEN [12] =
    '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31,
      5'd30, 5'd31};

  typedef enum logic [3:0] {
    ERR_NONE           = 4'd0,
    ERR_EMPTY          = 4'd1,
    ERR_NO_YEAR        = 4'd2,
    ERR_NO_DAY         = 4'd3,
    ERR_ORD_YEAR_CHAR  = 4'd4,
    ERR_ORD_YEAR_RANGE = 4'd5,
    ERR_ORD_DAY_CHAR   = 4'd6,
    ERR_ORD_DAY_RANGE  = 4'd7,
    ERR_ISO_LAYOUT     = 4'd8,
    ERR_ISO_YEAR       = 4'd9,
    ERR_ISO_MONTH      = 4'd10,
    ERR_ISO_DAY        = 4'd11
  } dsp_err_t;

  // Running state of the string being received
  typedef struct packed {
    logic [3:0]  char_count;
    logic        dot_seen;
    logic        dot_at_start;
    logic [13:0] bd_value;
    logic [8:0]  bd_mod400;
    logic        bd_bad;
    logic [8:0]  ad_value;
    logic        ad_bad;
    logic [6:0]  iso_month;
    logic [6:0]  iso_day;
    logic [3:0]  iso_flags;
  } dsp_state_t;

  // Finished string handed to the checker
  typedef struct packed {
    logic       empty;
    logic       dot_is_last;
    dsp_state_t st;
  } dsp_snap_t;

  // Remainder by 400 of a value below 4000: compare against each multiple
  function automatic logic [8:0] mod400(input logic [11:0] v);
    logic [3:0]  q;
    logic [11:0] r;
    q = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 12'(LEAP_CYCLE * k)) q = 4'(k);
    end
    r = v - 12'(q) * 12'(LEAP_CYCLE);
    return r[8:0];
  endfunction

  // Gregorian leap rule on the year mod 400
  function automatic logic is_leap(input logic [8:0] m);
    return (m[1:0] == 2'd0) && (m != 9'd100) && (m != 9'd200) && (m != 9'd300);
  endfunction

endpackage

>>> rtl/core/dsp_absorb.sv
// Per-character state update and snapshot register of the finished string.
module dsp_absorb (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  input  logic              empty_string,
  input  logic              snap_take,
  output logic              snap_valid,
  output dsp_pkg::dsp_snap_t snap
);
  import dsp_pkg::*;

  dsp_state_t  st;
  dsp_state_t  st_next;
  logic        dig;
  logic [3:0]  dval;
  logic        dot_is_last;
  logic [16:0] bd_prod;
  logic [11:0] mod_prod;
  logic [11:0] ad_prod;
  logic        done;

  assign dig         = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign dval        = dig ? char_code[3:0] : 4'd0;
  assign dot_is_last = (char_code == CHAR_DOT) && !st.dot_seen;
  assign bd_prod     = 17'(st.bd_value) * 17'd10 + 17'(dval);
  assign mod_prod    = 12'(st.bd_mod400) * 12'd10 + 12'(dval);
  assign ad_prod     = 12'(st.ad_value) * 12'd10 + 12'(dval);
  assign done        = accept && (last_char || empty_string);

  always_comb begin
    st_next = st;
    // Ordinal reading: split at the first dot
    if (!st.dot_seen) begin
      if (char_code == CHAR_DOT) begin
        st_next.dot_seen     = 1'b1;
        st_next.dot_at_start = (st.char_count == 4'd0);
      end else if (dig && !st.bd_bad) begin
        st_next.bd_value  = (bd_prod > 17'(YEAR_SAT)) ? YEAR_SAT : bd_prod[13:0];
        st_next.bd_mod400 = mod400(mod_prod);
      end else begin
        st_next.bd_bad = 1'b1;
      end
    end else begin
      if (dig && !st.ad_bad) begin
        st_next.ad_value = (ad_prod > 12'(DAY_SAT)) ? DAY_SAT : ad_prod[8:0];
      end else begin
        st_next.ad_bad = 1'b1;
      end
    end
    // ISO reading: fixed positions
    if (st.char_count <= 4'd3) begin
      if (!dig) st_next.iso_flags[FLAG_YEAR] = 1'b1;
    end else if (st.char_count == 4'd4 || st.char_count == 4'd7) begin
      if (char_code != CHAR_DASH) st_next.iso_flags[FLAG_DASH] = 1'b1;
    end else if (st.char_count == 4'd5 || st.char_count == 4'd6) begin
      if (dig) st_next.iso_month = 7'(st.iso_month * 7'd10 + 7'(dval));
      else st_next.iso_flags[FLAG_MONTH] = 1'b1;
    end else if (st.char_count == 4'd8 || st.char_count == 4'd9) begin
      if (dig) st_next.iso_day = 7'(st.iso_day * 7'd10 + 7'(dval));
      else st_next.iso_flags[FLAG_DAY] = 1'b1;
    end
    if (st.char_count != CNT_MAX) st_next.char_count = st.char_count + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept) begin
        st <= (last_char || empty_string) ? '0 : st_next;
      end
      if (done) begin
        snap_valid <= 1'b1;
      end else if (snap_take) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      snap.empty       <= empty_string;
      snap.dot_is_last <= dot_is_last;
      snap.st          <= st_next;
    end
  end

`ifndef ASSERT_OFF
  a_dot_start: assert property (@(posedge clk) disable iff (rst)
    st.dot_at_start |-> st.dot_seen)
    else $error("dot at start recorded without a dot");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    (st.bd_value <= YEAR_SAT) && (st.ad_value <= DAY_SAT))
    else $error("accumulator above saturation limit");
  a_mod: assert property (@(posedge clk) disable iff (rst)
    st.bd_mod400 < 9'(LEAP_CYCLE))
    else $error("year remainder out of range");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    done |=> (st.char_count == 4'd0) && !st.dot_seen && (st.iso_flags == 4'd0))
    else $error("state not cleared after end of string");
`endif

endmodule

>>> rtl/core/dsp_check.sv
// Final layout and range check of a finished string, with the result register.
module dsp_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               snap_valid,
  input  dsp_pkg::dsp_snap_t snap,
  input  logic               out_ready,
  output logic               snap_take,
  output logic               out_valid,
  output logic               date_valid,
  output logic [13:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic [3:0]         error_code
);
  import dsp_pkg::*;

  dsp_state_t s;
  logic       lp;
  logic [8:0] ord_max;
  logic [3:0] ord_m;
  logic [3:0] ord_idx;
  logic [8:0] ord_start;
  logic [8:0] ord_day;
  logic       iso_m_ok;
  logic [3:0] iso_idx;
  logic [4:0] iso_lim;
  logic       r_valid;
  logic [3:0] r_month;
  logic [4:0] r_day;
  dsp_err_t   r_err;

  assign s         = snap.st;
  assign snap_take = !out_valid || out_ready;
  assign lp        = is_leap(s.bd_mod400);
  assign ord_max   = lp ? ORD_DAYS_LP : ORD_DAYS;

  // Month of an ordinal day: last month whose start lies below the day
  always_comb begin
    ord_m = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (s.ad_value > MONTH_START[k] + ((k >= 2 && lp) ? 9'd1 : 9'd0)) ord_m = 4'(k + 1);
    end
  end

  assign ord_idx   = ord_m - 4'd1;
  assign ord_start = MONTH_START[ord_idx] + ((ord_m >= 4'd3 && lp) ? 9'd1 : 9'd0);
  assign ord_day   = s.ad_value - ord_start;

  assign iso_m_ok = (s.iso_month != 7'd0) && (s.iso_month <= MONTH_LAST);
  assign iso_idx  = iso_m_ok ? 4'(s.iso_month - 7'd1) : 4'd0;
  assign iso_lim  = (iso_idx == MONTH_FEB - 4'd1 && lp) ? 5'd29 : MONTH_LEN[iso_idx];

  always_comb begin
    r_valid = 1'b0;
    r_month = 4'd0;
    r_day   = 5'd0;
    r_err   = ERR_NONE;
    priority if (snap.empty) begin
      r_err = ERR_EMPTY;
    end else if (s.dot_seen) begin
      priority if (s.dot_at_start) r_err = ERR_NO_YEAR;
      else if (snap.dot_is_last) r_err = ERR_NO_DAY;
      else if (s.bd_bad) r_err = ERR_ORD_YEAR_CHAR;
      else if (s.bd_value == 14'd0 || s.bd_value > YEAR_MAX) r_err = ERR_ORD_YEAR_RANGE;
      else if (s.ad_bad) r_err = ERR_ORD_DAY_CHAR;
      else if (s.ad_value == 9'd0 || s.ad_value > ord_max) r_err = ERR_ORD_DAY_RANGE;
      else begin
        r_valid = 1'b1;
        r_month = ord_m;
        r_day   = ord_day[4:0];
      end
    end else begin
      priority if (s.char_count != ISO_LEN || s.iso_flags[FLAG_DASH]) r_err = ERR_ISO_LAYOUT;
      else if (s.iso_flags[FLAG_YEAR] || s.bd_value == 14'd0) r_err = ERR_ISO_YEAR;
      else if (s.iso_flags[FLAG_MONTH] || !iso_m_ok) r_err = ERR_ISO_MONTH;
      else if (s.iso_flags[FLAG_DAY] || s.iso_day == 7'd0 || s.iso_day > 7'(iso_lim)) begin
        r_err = ERR_ISO_DAY;
      end else begin
        r_valid = 1'b1;
        r_month = s.iso_month[3:0];
        r_day   = s.iso_day[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_take) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && snap_valid) begin
      date_valid <= r_valid;
      year_out   <= r_valid ? s.bd_value : 14'd0;
      month_out  <= r_month;
      day_out    <= r_day;
      error_code <= r_err;
    end
  end

`ifndef ASSERT_OFF
  a_good: assert property (@(posedge clk) disable iff (rst)
    out_valid && date_valid |-> (error_code == ERR_NONE) && (year_out != 14'd0) &&
      (month_out != 4'd0) && (month_out <= 4'd12) && (day_out != 5'd0))
    else $error("valid date with bad fields");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && !date_valid |-> (error_code != ERR_NONE) && (year_out == 14'd0) &&
      (month_out == 4'd0) && (day_out == 5'd0))
    else $error("invalid date with nonzero fields");
  a_load: assert property (@(posedge clk) disable iff (rst)
    snap_valid && snap_take |=> out_valid)
    else $error("snapshot taken but no result presented");
`endif

endmodule

>>> rtl/core/date_string_parser.sv
// Date string parser: one character per request, one result per string.
// Path: the request carrying the last character (or the empty-string flag) is
//   captured in the snapshot register, then checked into the result register behind m_tvalid.
// Throughput: one character per cycle; s_tready drops only while a finished
//   string waits in the snapshot register behind a stalled result register.
// Reset: synchronous rst clears the running state and both valid flags.
module date_string_parser (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  input  logic        s_tuser,   // [0] empty_string
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [13:0] year_out, [17:14] month_out,
                                 // [22:18] day_out, [26:23] error_code, rest zero
  output logic        m_tuser    // [0] date_valid
);
  import dsp_pkg::*;

  logic        accept;
  logic        snap_valid;
  logic        snap_take;
  dsp_snap_t   snap;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [3:0]  error_code;

  // Take a new character unless a finished string is stuck in the snapshot
  assign s_tready = !snap_valid || snap_take;
  assign accept   = s_tvalid && s_tready;

  // Accumulate both readings; capture the string when it ends
  dsp_absorb u_absorb (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (s_tdata),
    .last_char    (s_tlast),
    .empty_string (s_tuser),
    .snap_take    (snap_take),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  // Check layout and ranges, convert ordinal days, hold the result
  dsp_check u_check (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .out_ready  (m_tready),
    .snap_take  (snap_take),
    .out_valid  (m_tvalid),
    .date_valid (m_tuser),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .error_code (error_code)
  );

  // Pack result fields from the lowest bit up
  assign m_tdata = {5'd0, error_code, day_out, month_out, year_out};

endmodule
